// ===== hw/rtl/cpbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpbt_pkg
// Shared types and constants for the clip player with beep tone: op codes,
// tone request record, fixed-point constants of the sine and tone envelope.
// ----------------------------------------------------------------------------
package cpbt_pkg;

   // request op codes
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_COMMIT = 2'd2
   } op_type;

   // field widths
   localparam int LEN_W    = 17;
   localparam int FRAMES_W = 12;
   localparam int TERM_W   = 14;

   // beep control
   localparam logic [FRAMES_W-1:0] TONE_FRAMES = 12'd4000;
   localparam logic [31:0]         INC_HIGH    = 32'd98426334;  // 1100 Hz at 48 kHz
   localparam logic [31:0]         INC_LOW     = 32'd62634940;  // 700 Hz at 48 kHz
   localparam logic [7:0]          HIGH_LEVEL  = 8'd191;

   // clip gain, unsigned Q4.12
   localparam logic [15:0] GAIN_UNITY = 16'd4096;
   localparam logic [32:0] ROUND_BIAS = 33'd2048;

   // quarter-wave sine polynomial, Q14 argument
   localparam logic [14:0] SINE_QUARTER = 15'd16384;
   localparam logic [15:0] SINE_A       = 16'd51472;
   localparam logic [14:0] SINE_B       = 15'd21167;
   localparam logic [11:0] SINE_C       = 12'd2611;
   localparam logic [14:0] SINE_MAX     = 15'd32767;

   // envelope divide by 16000 via reciprocal, floor(2^27 / 16000)
   localparam logic [13:0] TONE_DIV   = 14'd16000;
   localparam logic [13:0] TONE_RECIP = 14'd8388;

   // register stages from tone request to tone term
   localparam int TONE_LAT = 11;

   // tone request handed from the front end to the tone pipeline
   typedef struct packed {
      logic [FRAMES_W-1:0] frames;
      logic [31:0]         phase;
   } tone_req_type;

endpackage

// ===== hw/rtl/cpbt_clip_ram.sv =====
// ----------------------------------------------------------------------------
// cpbt_clip_ram
// Clip sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpbt_clip_ram #(
   parameter int DEPTH = 65536
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [15:0]         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [15:0]         rd_data
);

   logic signed [15:0] mem [DEPTH];
   logic signed [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cpbt_tone_gen.sv =====
// ----------------------------------------------------------------------------
// cpbt_tone_gen
// Beep tone pipeline: phase to table index, index to quarter-wave angle,
// polynomial sine, envelope scaling by frames left over 16000.
// ----------------------------------------------------------------------------
module cpbt_tone_gen #(
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                adv,
   input  cpbt_pkg::tone_req_type              req,
   output logic signed [cpbt_pkg::TERM_W-1:0]  term
);
   import cpbt_pkg::*;

   localparam int IW         = $clog2(SINE_ENTRIES);
   localparam int NW         = $clog2(SINE_ENTRIES + 1);
   localparam int TURN_RECIP = (2 ** 28) / SINE_ENTRIES;
   localparam int MW         = $clog2(TURN_RECIP + 1);
   localparam int KW         = IW + MW;
   localparam int XW         = IW + 17;

   // stage registers
   logic [IW-1:0]       idx2_ff;
   logic [IW-1:0]       idx3_ff;
   logic [IW-1:0]       idx4_ff;
   logic [KW-1:0]       km_ff;
   logic [15:0]         q0_ff;
   logic [XW-1:0]       qn_ff;
   logic [14:0]         u_dly_ff [4];
   logic [14:0]         z2_6_ff;
   logic [14:0]         z2_7_ff;
   logic [14:0]         r2_ff;
   logic [15:0]         r4_ff;
   logic [14:0]         mag_ff;
   logic [26:0]         tprod_ff;
   logic [26:0]         tprod11_ff;
   logic [13:0]         qa_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic [FRAMES_W-1:0] frames_dly_ff [8];
   logic                neg_dly_ff [7];

   // next values
   logic [32+NW-1:0]    ph_prod;
   logic [IW-1:0]       idx_in;
   logic [KW-1:0]       km_in;
   logic [15:0]         q0_in;
   logic [XW-1:0]       qn_in;
   logic [XW-1:0]       turn_x;
   logic [XW-1:0]       turn_rem;
   logic [15:0]         turn;
   logic [14:0]         u_in;
   logic                neg_in;
   logic [29:0]         uu_prod;
   logic [14:0]         z2_in;
   logic [26:0]         c_prod;
   logic [14:0]         r2_in;
   logic [29:0]         b_prod;
   logic [15:0]         r4_in;
   logic [30:0]         a_prod;
   logic [15:0]         r5;
   logic [14:0]         mag_in;
   logic [26:0]         tprod_in;
   logic [40:0]         recip_prod;
   logic [13:0]         qa_in;
   logic [26:0]         qa_back;
   logic [26:0]         env_rem;
   logic [13:0]         env_mag;
   logic signed [TERM_W-1:0] term_in;

   // table index, then angle = floor(index * 65536 / entries) with one correction
   always_comb begin
      ph_prod  = (32+NW)'(req.phase) * (32+NW)'(SINE_ENTRIES);
      idx_in   = ph_prod[32 +: IW];
      km_in    = KW'(idx2_ff) * KW'(TURN_RECIP);
      q0_in    = km_ff[12 +: 16];
      qn_in    = XW'(q0_in) * XW'(SINE_ENTRIES);
      turn_x   = XW'({idx4_ff, 16'b0});
      turn_rem = turn_x - qn_ff;
      turn     = (turn_rem >= XW'(SINE_ENTRIES)) ? q0_ff + 16'd1 : q0_ff;
      neg_in   = turn[15];
      u_in     = turn[14] ? (SINE_QUARTER - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
   end

   // quarter-wave polynomial
   always_comb begin
      uu_prod = 30'(u_dly_ff[0]) * 30'(u_dly_ff[0]);
      z2_in   = uu_prod[28:14];
      c_prod  = 27'(SINE_C) * 27'(z2_6_ff);
      r2_in   = SINE_B - {3'b0, c_prod[25:14]};
      b_prod  = 30'(r2_ff) * 30'(z2_7_ff);
      r4_in   = SINE_A - {1'b0, b_prod[28:14]};
      a_prod  = 31'(r4_ff) * 31'(u_dly_ff[3]);
      r5      = a_prod[29:14];
      mag_in  = (r5 > {1'b0, SINE_MAX}) ? SINE_MAX : r5[14:0];
   end

   // envelope: magnitude * frames / 16000, truncated
   always_comb begin
      tprod_in   = 27'(mag_ff) * 27'(frames_dly_ff[7]);
      recip_prod = 41'(tprod_ff) * 41'(TONE_RECIP);
      qa_in      = recip_prod[40:27];
      qa_back    = 27'(qa_ff) * 27'(TONE_DIV);
      env_rem    = tprod11_ff - qa_back;
      env_mag    = (env_rem >= 27'(TONE_DIV)) ? qa_ff + 14'd1 : qa_ff;
      term_in    = neg_dly_ff[6] ? -$signed(env_mag) : $signed(env_mag);
   end

   // pipeline advance
   always_ff @(posedge clock) begin
      if (adv) begin
         idx2_ff          <= idx_in;
         idx3_ff          <= idx2_ff;
         km_ff            <= km_in;
         idx4_ff          <= idx3_ff;
         q0_ff            <= q0_in;
         qn_ff            <= qn_in;
         u_dly_ff[0]      <= u_in;
         neg_dly_ff[0]    <= neg_in;
         z2_6_ff          <= z2_in;
         z2_7_ff          <= z2_6_ff;
         r2_ff            <= r2_in;
         r4_ff            <= r4_in;
         mag_ff           <= mag_in;
         tprod_ff         <= tprod_in;
         tprod11_ff       <= tprod_ff;
         qa_ff            <= qa_in;
         term_ff          <= term_in;
         frames_dly_ff[0] <= req.frames;
         for (int i = 1; i < 8; i++) begin
            frames_dly_ff[i] <= frames_dly_ff[i-1];
         end
         for (int i = 1; i < 7; i++) begin
            neg_dly_ff[i] <= neg_dly_ff[i-1];
         end
         for (int i = 1; i < 4; i++) begin
            u_dly_ff[i] <= u_dly_ff[i-1];
         end
      end
   end

   assign term = term_ff;

endmodule

// ===== hw/rtl/clip_player_with_beep_tone_unit.sv =====
// A tick's frame passes the tone request register, the tone stages and the output register to rsp_valid.
// Throughput: one request per cycle while rsp_ready is high; the whole
// pipeline stalls only when the output register is full and not taken.
// Depth is set by the tone path (table index, angle, sine polynomial, envelope).
// Reset clears play position, clip length, beep state and sets gain to unity;
// the clip store is not cleared and must be written before it is played.
// ----------------------------------------------------------------------------
// clip_player_with_beep_tone_unit
// Mono frame source: clip playback from a sample store times a gain, mixed
// with a decaying one-shot beep, saturated to 16 bits.
// ----------------------------------------------------------------------------
module clip_player_with_beep_tone_unit #(
   parameter int CLIP_DEPTH   = 65536,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [15:0]                  csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [7:0]                   req_beep_level,
   input  logic signed [15:0]           req_sample_value,
   input  logic [15:0]                  req_sample_index,
   input  logic [cpbt_pkg::LEN_W-1:0]   req_new_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_audio_out,
   output logic                         rsp_playing
);
   import cpbt_pkg::*;

   localparam int AW       = $clog2(CLIP_DEPTH);
   localparam int PW       = $clog2(CLIP_DEPTH + 1);
   localparam int CW       = (PW > LEN_W) ? PW : LEN_W;
   localparam int PIPE     = TONE_LAT + 1;
   localparam int CLIP_DLY = TONE_LAT - 1;
   localparam int SUM_W    = 22;

   // handshake and decode
   logic adv;
   logic accept;
   logic is_tick;
   logic is_write;
   logic is_commit;

   // clip position and length
   logic [CW-1:0] depth_ext;
   logic [CW-1:0] index_ext;
   logic [CW-1:0] length_ext;
   logic [CW-1:0] size_sel;
   logic          wr_ok;
   logic          play_ok;
   logic          playing_in;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [PW-1:0] size_ff;
   logic [PW-1:0] size_in;

   // beep state
   logic                trigger;
   logic                high_eff;
   logic [FRAMES_W-1:0] frames_eff;
   logic [31:0]         phase_step;
   logic [FRAMES_W-1:0] frames_ff;
   logic [FRAMES_W-1:0] frames_in;
   logic [31:0]         phase_ff;
   logic [31:0]         phase_in;
   logic                high_ff;
   logic                high_in;
   logic                prev_ff;
   logic                prev_in;
   tone_req_type        tone_req_in;
   tone_req_type        tone_req_ff;

   // gain register
   logic [15:0] gain_ff;

   // pipeline
   logic                     valid_ff [PIPE];
   logic                     play_dly_ff [PIPE];
   logic                     clip_on_ff;
   logic signed [15:0]       rd_data;
   logic signed [32:0]       prod_in;
   logic signed [32:0]       prod_ff;
   logic signed [32:0]       prod_rnd;
   logic signed [20:0]       clip_dly_ff [CLIP_DLY];
   logic signed [TERM_W-1:0] tone_term;
   logic signed [SUM_W-1:0]  sum;
   logic signed [15:0]       sat_in;

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_audio_out_ff;
   logic               rsp_playing_ff;

   // handshake: move when the output register is free or being taken
   always_comb begin
      adv       = !rsp_valid_ff || rsp_ready;
      accept    = req_valid && adv;
      is_tick   = 1'b0;
      is_write  = 1'b0;
      is_commit = 1'b0;
      unique case (req_op)
         OP_TICK:   is_tick   = 1'b1;
         OP_WRITE:  is_write  = 1'b1;
         OP_COMMIT: is_commit = 1'b1;
         default:   is_tick   = 1'b0;
      endcase
   end

   // play position and clip length
   always_comb begin
      depth_ext  = CW'(CLIP_DEPTH);
      index_ext  = CW'(req_sample_index);
      length_ext = CW'(req_new_length);
      wr_ok      = index_ext < depth_ext;
      size_sel   = (length_ext > depth_ext) ? depth_ext : length_ext;
      play_ok    = pos_ff < size_ff;
      pos_in     = pos_ff;
      size_in    = size_ff;
      if (accept && is_commit) begin
         size_in = size_sel[PW-1:0];
         pos_in  = '0;
      end else if (accept && is_tick && play_ok) begin
         pos_in = pos_ff + 1'b1;
      end
      playing_in = pos_in < size_ff;
   end

   // beep trigger, phase advance and frame count
   always_comb begin
      trigger            = (req_beep_level != 8'd0) && !prev_ff;
      frames_eff         = trigger ? TONE_FRAMES : frames_ff;
      high_eff           = trigger ? (req_beep_level > HIGH_LEVEL) : high_ff;
      phase_step         = high_eff ? INC_HIGH : INC_LOW;
      tone_req_in.frames = frames_eff;
      tone_req_in.phase  = phase_ff + phase_step;
      frames_in          = frames_ff;
      phase_in           = phase_ff;
      high_in            = high_ff;
      prev_in            = prev_ff;
      if (accept && is_tick) begin
         prev_in = req_beep_level != 8'd0;
         high_in = high_eff;
         if (frames_eff != '0) begin
            frames_in = frames_eff - 1'b1;
            phase_in  = tone_req_in.phase;
         end else begin
            frames_in = frames_eff;
         end
      end
   end

   // control state and valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         size_ff      <= '0;
         frames_ff    <= '0;
         phase_ff     <= '0;
         high_ff      <= 1'b0;
         prev_ff      <= 1'b0;
         gain_ff      <= GAIN_UNITY;
         clip_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PIPE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         pos_ff    <= pos_in;
         size_ff   <= size_in;
         frames_ff <= frames_in;
         phase_ff  <= phase_in;
         high_ff   <= high_in;
         prev_ff   <= prev_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (adv) begin
            clip_on_ff   <= accept && is_tick && play_ok;
            valid_ff[0]  <= accept && is_tick;
            for (int i = 1; i < PIPE; i++) begin
               valid_ff[i] <= valid_ff[i-1];
            end
            rsp_valid_ff <= valid_ff[PIPE-1];
         end
      end
   end

   // clip store
   cpbt_clip_ram #(
      .DEPTH (CLIP_DEPTH)
   ) u_clip_ram (
      .clock   (clock),
      .wr_en   (accept && is_write && wr_ok),
      .wr_addr (index_ext[AW-1:0]),
      .wr_data (req_sample_value),
      .rd_en   (adv),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // beep tone pipeline
   cpbt_tone_gen #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_tone_gen (
      .clock (clock),
      .adv   (adv),
      .req   (tone_req_ff),
      .term  (tone_term)
   );

   // clip gain, rounding, mix and saturation
   always_comb begin
      prod_in  = clip_on_ff ? 33'(rd_data) * 33'($signed({1'b0, gain_ff})) : '0;
      prod_rnd = prod_ff + $signed(ROUND_BIAS);
      sum      = SUM_W'(clip_dly_ff[CLIP_DLY-1]) + SUM_W'(tone_term);
      if (sum > 22'sd32767) begin
         sat_in = 16'sh7fff;
      end else if (sum < -22'sd32768) begin
         sat_in = -16'sh8000;
      end else begin
         sat_in = sum[15:0];
      end
   end

   // payload pipeline and output register
   always_ff @(posedge clock) begin
      if (adv) begin
         tone_req_ff    <= tone_req_in;
         prod_ff        <= prod_in;
         clip_dly_ff[0] <= prod_rnd[32:12];
         for (int i = 1; i < CLIP_DLY; i++) begin
            clip_dly_ff[i] <= clip_dly_ff[i-1];
         end
         play_dly_ff[0] <= playing_in;
         for (int i = 1; i < PIPE; i++) begin
            play_dly_ff[i] <= play_dly_ff[i-1];
         end
         rsp_audio_out_ff <= sat_in;
         rsp_playing_ff   <= play_dly_ff[PIPE-1];
      end
   end

   assign req_ready     = adv;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_audio_out = rsp_audio_out_ff;
   assign rsp_playing   = rsp_playing_ff;

endmodule

// ===== tb/tb_clip_player_with_beep_tone_unit.sv =====
// ----------------------------------------------------------------------------
// tb_clip_player_with_beep_tone_unit
// Self-checking bench for the clip player with beep tone. Requests go in over
// a valid/ready channel. A cycle-free model of the clip store, play position,
// gain and beep oscillator predicts every frame. Frames coming back are
// checked in order against that prediction. Directed cases come first, then
// randomized clip/commit/play scenes across several gain settings, then a
// long stretch of one beep decay. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_clip_player_with_beep_tone_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cpbt_pkg::*;

   // bench constants
   localparam int          STORE_DEPTH = 65536;
   localparam int          SINE_SIZE   = 1024;
   localparam int          BEEP_LEN    = 4000;
   localparam int          RUNOUT_LEN  = 300;
   localparam int unsigned STEP_1100   = 32'd98426334;
   localparam int unsigned STEP_700    = 32'd62634940;
   localparam logic [1:0]  OP_SPARE    = 2'd3;
   localparam int          DRAIN_PAD   = 20;
   localparam int          CYCLE_LIMIT = 600000;

   typedef struct {
      logic signed [15:0] audio;
      logic               playing;
   } audio_frame_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // block ports
   logic                     csr_wr_en        = 1'b0;
   logic [15:0]              csr_wr_data      = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_op           = OP_TICK;
   logic [7:0]               req_beep_level   = '0;
   logic signed [15:0]       req_sample_value = '0;
   logic [15:0]              req_sample_index = '0;
   logic [LEN_W-1:0]         req_new_length   = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [15:0]       rsp_audio_out;
   logic                     rsp_playing;

   clip_player_with_beep_tone_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_beep_level   (req_beep_level),
      .req_sample_value (req_sample_value),
      .req_sample_index (req_sample_index),
      .req_new_length   (req_new_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_audio_out    (rsp_audio_out),
      .rsp_playing      (rsp_playing)
   );

   // mirrored block state
   logic signed [15:0] clip_mem [STORE_DEPTH];
   bit                 loaded   [STORE_DEPTH];
   int                 play_pos     = 0;
   int                 clip_len     = 0;
   int                 beep_left    = 0;
   bit [31:0]          beep_phase   = '0;
   bit                 beep_high    = 1'b0;
   bit                 level_was_on = 1'b0;
   bit [15:0]          clip_gain    = 16'd4096;

   // expected frames, oldest first
   audio_frame_type frames_due [$];

   // run bookkeeping
   bit        no_gaps     = 1'b0;
   logic [7:0] beep_knob  = '0;
   int        items_sent  = 0;
   int        frames_seen = 0;
   int        n_writes    = 0;
   int        n_commits   = 0;
   int        n_spare     = 0;
   int        n_beeps     = 0;
   int        n_clipped   = 0;
   int        n_gains     = 0;
   int        errors      = 0;
   int        cycle_count = 0;
   int        stall_left  = 0;
   int        stall_draw;

   // quarter-wave polynomial sine, one table entry
   function automatic longint sine_entry(input longint k);
      longint t, u, z2, r;
      int     quad;
      t    = ((k * 65536) / SINE_SIZE) & 'hFFFF;
      quad = int'(t >> 14);
      u    = t & 'h3FFF;
      if (quad[0]) u = 16384 - u;
      z2 = (u * u) >>> 14;
      r  = (2611 * z2) >>> 14;
      r  = 21167 - r;
      r  = (r * z2) >>> 14;
      r  = 51472 - r;
      r  = (r * u) >>> 14;
      if (r > 32767) r = 32767;
      return quad[1] ? -r : r;
   endfunction

   // advance the model by one tick and return the frame it produces
   function automatic audio_frame_type mix_next_frame(input logic [7:0] level);
      audio_frame_type f;
      longint          mix, s, mag, idx;
      mix = 0;
      // beep trigger on a rise from zero, phase is kept
      if (level != 0 && !level_was_on) begin
         beep_high = level > 8'd191;
         beep_left = BEEP_LEN;
         n_beeps++;
      end
      level_was_on = level != 0;
      // clip term, rounded Q4.12 gain
      if (play_pos < clip_len) begin
         mix = (longint'(clip_mem[play_pos]) * longint'(clip_gain) + 2048) >>> 12;
         play_pos++;
      end
      // beep term with linear decay
      if (beep_left > 0) begin
         beep_phase += beep_high ? STEP_1100 : STEP_700;
         idx = (longint'(beep_phase) * SINE_SIZE) >> 32;
         s   = sine_entry(idx);
         mag = ((s < 0 ? -s : s) * beep_left) / 16000;
         mix += (s < 0) ? -mag : mag;
         beep_left--;
      end
      // saturate to 16 bits
      if (mix > 32767 || mix < -32768) n_clipped++;
      if (mix > 32767) mix = 32767;
      if (mix < -32768) mix = -32768;
      f.audio   = mix[15:0];
      f.playing = play_pos < clip_len;
      return f;
   endfunction

   // one request transfer, then the model follows it
   task automatic send_req(input logic [1:0] op, input logic [7:0] level,
                           input logic signed [15:0] value, input logic [15:0] index,
                           input logic [LEN_W-1:0] length);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_beep_level   <= level;
      req_sample_value <= value;
      req_sample_index <= index;
      req_new_length   <= length;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer done, update the mirror
      case (op)
         OP_TICK: begin
            frames_due.push_back(mix_next_frame(level));
         end
         OP_WRITE: begin
            clip_mem[index] = value;
            loaded[index]   = 1'b1;
            n_writes++;
         end
         OP_COMMIT: begin
            clip_len = (length > STORE_DEPTH) ? STORE_DEPTH : int'(length);
            play_pos = 0;
            n_commits++;
         end
         default: n_spare++;
      endcase
      if (op != OP_SPARE) items_sent++;
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_sample(input logic [15:0] index, input logic signed [15:0] value);
      send_req(OP_WRITE, 8'($urandom), value, index, 17'($urandom_range(0, STORE_DEPTH)));
   endtask

   task automatic commit_clip(input int len);
      send_req(OP_COMMIT, 8'($urandom), 16'($urandom), 16'($urandom), 17'(len));
   endtask

   // tick one frame; a store entry about to be played is written first if it was never written
   task automatic play_tick(input logic [7:0] level);
      if (play_pos < clip_len && !loaded[play_pos])
         write_sample(16'(play_pos), rand_sample());
      send_req(OP_TICK, level, 16'($urandom), 16'($urandom),
               17'($urandom_range(0, STORE_DEPTH)));
   endtask

   // let every expected frame arrive and the pipeline empty
   task automatic settle_pipe();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic set_gain(input logic [15:0] g);
      settle_pipe();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clip_gain = g;
      n_gains++;
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'd1;
         1:       return 8'd191;
         2:       return 8'd192;
         3:       return 8'd255;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // slowly wandering trigger level, mostly steady
   function automatic logic [7:0] next_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) beep_knob = (beep_knob == 0) ? pick_level() : 8'd0;
      else if (r < 6 && beep_knob != 0) beep_knob = pick_level();
      return beep_knob;
   endfunction

   // timeout watch; the frame checker and ready staller follow
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames still due", cycle_count,
                  frames_due.size());
         $display("tb_clip_player_with_beep_tone_unit: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         // compare against the oldest expected frame
         if (frames_due.size() == 0) begin
            if (errors < 10)
               $display("frame %0d: unexpected, audio %0d playing %0d", frames_seen,
                        rsp_audio_out, rsp_playing);
            errors++;
         end else begin
            if (rsp_audio_out !== frames_due[0].audio ||
                rsp_playing !== frames_due[0].playing) begin
               if (errors < 10)
                  $display("frame %0d: audio exp %0d got %0d, playing exp %0d got %0d",
                           frames_seen, frames_due[0].audio, rsp_audio_out,
                           frames_due[0].playing, rsp_playing);
               errors++;
            end
            void'(frames_due.pop_front());
         end
         frames_seen++;
         stall_draw = no_gaps ? 0 : $urandom_range(0, 8);
         if (stall_draw != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_draw;
         end
      end else if (!rsp_ready) begin
         if (stall_left <= 1) rsp_ready <= 1'b1;
         else stall_left <= stall_left - 1;
      end
   end

   // edges of every field, all ops, trigger and length corners
   task automatic test_directed();
      play_tick(8'd0);
      send_req(OP_SPARE, 8'($urandom), 16'($urandom), 16'($urandom),
               17'($urandom_range(0, STORE_DEPTH)));
      write_sample(16'd0, 16'sh7FFF);
      write_sample(16'd1, 16'sh8000);
      write_sample(16'd2, 16'sh0000);
      write_sample(16'hFFFF, -16'sd1);
      commit_clip(3);
      repeat (4) play_tick(8'd0);
      commit_clip(2);
      play_tick(8'd192);
      play_tick(8'd191);
      play_tick(8'd0);
      play_tick(8'd191);
      play_tick(8'd255);
      play_tick(8'd0);
      play_tick(8'd1);
      commit_clip(STORE_DEPTH);
      play_tick(8'd0);
      play_tick(8'd0);
      commit_clip(0);
   endtask

   // randomized write/commit/play scenes over several gain settings
   task automatic test_random_scenes(input int quota);
      logic [15:0] gain_plan [6] = '{16'd0, 16'd65535, 16'd1, 16'd32768, 16'd0, 16'd4096};
      int phase, goal, len, fill, plays, i;
      for (phase = 0; phase < 6; phase++) begin
         set_gain(phase == 4 ? 16'($urandom) : gain_plan[phase]);
         goal = items_sent + quota / 6;
         while (items_sent < goal) begin
            if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
            if ($urandom_range(0, 9) < 7) begin
               // clip scene: load, commit, play a short clip a little past its end, a long one in part
               case ($urandom_range(0, 7))
                  0:       len = 0;
                  1:       len = $urandom_range(25, 200);
                  2:       len = STORE_DEPTH - $urandom_range(0, 2);
                  default: len = $urandom_range(1, 24);
               endcase
               fill = (len < 40) ? len : 40;
               if ($urandom_range(0, 3) != 0)
                  for (i = 0; i < fill; i++) write_sample(16'(i), rand_sample());
               commit_clip(len);
               plays = ((len <= 40) ? len : $urandom_range(1, 40)) + $urandom_range(0, 4);
               for (i = 0; i < plays; i++) begin
                  case ($urandom_range(0, 39))
                     0:       write_sample(16'($urandom), rand_sample());
                     1:       commit_clip($urandom_range(0, len));
                     default: ;
                  endcase
                  play_tick(next_level());
               end
            end else begin
               // loose requests
               case ($urandom_range(0, 3))
                  0: write_sample(16'($urandom), rand_sample());
                  1: commit_clip($urandom_range(0, STORE_DEPTH));
                  2: send_req(OP_SPARE, 8'($urandom), 16'($urandom), 16'($urandom),
                              17'($urandom));
                  default: play_tick(next_level());
               endcase
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   // one low beep held steady through a long stretch of its decay
   task automatic test_tone_runout();
      int i;
      commit_clip(0);
      play_tick(8'd0);
      for (i = 0; i < RUNOUT_LEN; i++) begin
         no_gaps = i < RUNOUT_LEN / 2;
         play_tick(8'd100);
      end
      no_gaps = 1'b0;
   endtask

   // test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_scenes(850);
      test_tone_runout();
      settle_pipe();
      $display("frames %0d, sample writes %0d, commits %0d, spare ops %0d, gains %0d",
               frames_seen, n_writes, n_commits, n_spare, n_gains);
      $display("beep starts %0d, saturated frames %0d, mismatches %0d",
               n_beeps, n_clipped, errors);
      if (errors == 0)
         $display("tb_clip_player_with_beep_tone_unit: done, clean");
      else
         $display("tb_clip_player_with_beep_tone_unit: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cpbt_pkg.sv
hw/rtl/cpbt_clip_ram.sv
hw/rtl/cpbt_tone_gen.sv
hw/rtl/clip_player_with_beep_tone_unit.sv
tb/tb_clip_player_with_beep_tone_unit.sv
